>>> hw/rtl/smpc_pkg.sv
package smpc_pkg;

  // Sizing of the reading accumulator.
  localparam int SAMPLES_PER_READING = 10;
  localparam int ADC_BITS            = 10;

  // Field widths.
  localparam int RAW_W   = 10;
  localparam int PCT_W   = 7;
  localparam int TEMP_W  = 8;
  localparam int SUM_W   = 14;
  localparam int CNT_W   = 4;
  localparam int CFG_W   = 10;
  localparam int CFG_A_W = 3;

  // Shared divider: the numerator covers |100 * (avg - wet_raw)|, the
  // denominator covers |dry_raw - wet_raw|.
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_CNT_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_WET_RAW   = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_DRY_RAW   = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_READ_MIN  = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_READ_MAX  = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_TEMP_THR  = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_HUMID_THR = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_SAT_LEVEL = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_DRY_LEVEL = 3'd7;

  // Reset values.
  localparam logic [RAW_W-1:0]         RST_WET_RAW    = 10'd256;
  localparam logic [RAW_W-1:0]         RST_DRY_RAW    = 10'd535;
  localparam logic [RAW_W-1:0]         RST_READ_MIN   = 10'd252;
  localparam logic [RAW_W-1:0]         RST_READ_MAX   = 10'd532;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_THR   = 8'sd30;
  localparam logic [PCT_W-1:0]         RST_HUMID_THR  = 7'd60;
  localparam logic [PCT_W-1:0]         RST_SAT_LEVEL  = 7'd60;
  localparam logic [PCT_W-1:0]         RST_DRY_LEVEL  = 7'd40;
  localparam logic [PCT_W-1:0]         RST_LAST_VALID = 7'd45;
  localparam logic [PCT_W-1:0]         PCT_FULL       = 7'd100;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } smpc_div_req_t;

endpackage

>>> hw/rtl/soil_moisture_pump_controller_core.sv
// Soil moisture pump controller.
// Input channel (in_valid / in_ready): one item per sample command or manual
// pump command. Result channel (out_valid / out_ready): exactly one result item
// per input item, carrying pump state, mode, moisture and reading flags.
// Configuration channel (cfg_valid / cfg_ready, always ready): cfg_index selects
// one of eight calibration and threshold registers; write only while idle.
// From input accept to out_valid, a manual command or a sample that does not
// end a reading passes the update and emit states; a reading that falls back
// to the last valid moisture also passes the control state; a reading with
// equal calibration points also waits for the average division, and a mapped
// reading for both. The two 17-step bit-serial divisions (average, then
// calibration scale) share one restoring divider, one bit per cycle.
// One item is in flight at a time; the next item can be accepted in the cycle
// after the result is loaded into the output register, even if that result
// still waits for out_ready. If the output register is still full when a new
// result is ready, the block holds that result and stops accepting until it
// drains.
// Reset (rst_n low at a clock edge) restores the default calibration, clears
// the sample accumulators, sets moisture to 0 with 45 as the fallback value,
// and puts the pump off in auto mode.
module soil_moisture_pump_controller_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input items.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic [smpc_pkg::RAW_W-1:0]             in_raw_sample,
  input  logic signed [smpc_pkg::TEMP_W-1:0]     in_temperature,
  input  logic [smpc_pkg::PCT_W-1:0]             in_humidity,
  input  logic                                   in_manual_on,
  // Result items.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_pump_on,
  output logic                                   out_manual_mode,
  output logic [smpc_pkg::PCT_W-1:0]             out_moisture_pct,
  output logic                                   out_reading_done,
  output logic                                   out_used_fallback,
  // Configuration writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smpc_pkg::CFG_A_W-1:0]           cfg_index,
  input  logic [smpc_pkg::CFG_W-1:0]             cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_MDIV = 3'd4;
  localparam logic [2:0] S_MAP  = 3'd5;
  localparam logic [2:0] S_CTRL = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [smpc_pkg::RAW_W-1:0] ADC_MASK =
    smpc_pkg::RAW_W'((1 << smpc_pkg::ADC_BITS) - 1);

  // Configuration registers.
  logic [smpc_pkg::RAW_W-1:0]           wet_raw_r;
  logic [smpc_pkg::RAW_W-1:0]           dry_raw_r;
  logic [smpc_pkg::RAW_W-1:0]           read_min_r;
  logic [smpc_pkg::RAW_W-1:0]           read_max_r;
  logic signed [smpc_pkg::TEMP_W-1:0]   temp_thr_r;
  logic [smpc_pkg::PCT_W-1:0]           humid_thr_r;
  logic [smpc_pkg::PCT_W-1:0]           sat_level_r;
  logic [smpc_pkg::PCT_W-1:0]           dry_level_r;

  // Block state.
  logic [2:0]                           state_r;
  logic [smpc_pkg::CNT_W-1:0]           sample_count_r;
  logic [smpc_pkg::SUM_W-1:0]           valid_sum_r;
  logic [smpc_pkg::CNT_W-1:0]           valid_count_r;
  logic [smpc_pkg::PCT_W-1:0]           moisture_r;
  logic [smpc_pkg::PCT_W-1:0]           last_valid_r;
  logic                                 mode_manual_r;
  logic                                 pump_r;

  // Latched item and working values.
  logic                                 cmd_r;
  logic [smpc_pkg::RAW_W-1:0]           raw_r;
  logic signed [smpc_pkg::TEMP_W-1:0]   temp_r;
  logic [smpc_pkg::PCT_W-1:0]           humid_r;
  logic                                 man_on_r;
  logic                                 done_r;
  logic                                 fallback_r;
  logic signed [smpc_pkg::RAW_W:0]      x_r;
  logic signed [17:0]                   n_r;
  logic                                 neg_r;

  // Output register.
  logic                                 out_valid_r;
  logic                                 out_pump_r;
  logic                                 out_mode_r;
  logic [smpc_pkg::PCT_W-1:0]           out_pct_r;
  logic                                 out_done_r;
  logic                                 out_fb_r;

  // Combinational helpers.
  logic [smpc_pkg::RAW_W-1:0]           raw_m;
  logic                                 in_window;
  logic [smpc_pkg::SUM_W-1:0]           sum_nxt;
  logic [smpc_pkg::CNT_W-1:0]           vcnt_nxt;
  logic [smpc_pkg::CNT_W-1:0]           scnt_nxt;
  logic                                 reading_end;
  logic signed [smpc_pkg::RAW_W:0]      span;
  logic signed [smpc_pkg::RAW_W:0]      x_nxt;
  logic signed [17:0]                   prod;
  logic signed [18:0]                   q_signed;
  logic signed [18:0]                   m_signed;
  logic [smpc_pkg::PCT_W-1:0]           m_clamped;
  logic                                 out_load;
  logic                                 auto_run;

  smpc_pkg::smpc_div_req_t              div_req;
  logic                                 div_done;
  logic [smpc_pkg::DIV_NUM_W-1:0]       div_quo;

  smpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sample accumulation for the latched item.
  always_comb begin
    raw_m       = raw_r & ADC_MASK;
    in_window   = (raw_m >= read_min_r) && (raw_m <= read_max_r);
    sum_nxt     = in_window ? valid_sum_r + smpc_pkg::SUM_W'(raw_m) : valid_sum_r;
    vcnt_nxt    = in_window ? valid_count_r + 1'b1 : valid_count_r;
    scnt_nxt    = sample_count_r + 1'b1;
    reading_end = scnt_nxt >= smpc_pkg::CNT_W'(smpc_pkg::SAMPLES_PER_READING);
  end

  // Calibration arithmetic: x = avg - wet_raw, n = -100 * x, d = dry_raw - wet_raw.
  always_comb begin
    span  = $signed({1'b0, dry_raw_r}) - $signed({1'b0, wet_raw_r});
    x_nxt = $signed({1'b0, div_quo[smpc_pkg::RAW_W-1:0]}) - $signed({1'b0, wet_raw_r});
    prod  = 18'(x_r) * 18'sd100;
  end

  // Signed truncating quotient, offset and clamp to 0..100.
  always_comb begin
    q_signed = neg_r ? 19'sd0 - $signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    m_signed = 19'sd100 + q_signed;
    if (m_signed < 19'sd0) begin
      m_clamped = '0;
    end else if (m_signed > 19'sd100) begin
      m_clamped = smpc_pkg::PCT_FULL;
    end else begin
      m_clamped = m_signed[smpc_pkg::PCT_W-1:0];
    end
  end

  // Divider requests: the average at the end of a reading, then the scale.
  always_comb begin
    div_req = '0;
    if (state_r == S_UPD && !cmd_r && reading_end && vcnt_nxt != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = smpc_pkg::DIV_NUM_W'(sum_nxt);
      div_req.divisor  = smpc_pkg::DIV_DEN_W'(vcnt_nxt);
    end else if (state_r == S_MDIV && span != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = n_r[17] ? smpc_pkg::DIV_NUM_W'(18'sd0 - n_r)
                                 : n_r[smpc_pkg::DIV_NUM_W-1:0];
      div_req.divisor  = span[smpc_pkg::RAW_W] ? smpc_pkg::DIV_DEN_W'(11'sd0 - span)
                                               : span[smpc_pkg::DIV_DEN_W-1:0];
    end
  end

  // Auto pump decision from the fresh moisture and the item's weather.
  assign auto_run = (moisture_r < dry_level_r) && (temp_r > temp_thr_r) &&
                    (humid_r < humid_thr_r);

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_raw_r   <= smpc_pkg::RST_WET_RAW;
      dry_raw_r   <= smpc_pkg::RST_DRY_RAW;
      read_min_r  <= smpc_pkg::RST_READ_MIN;
      read_max_r  <= smpc_pkg::RST_READ_MAX;
      temp_thr_r  <= smpc_pkg::RST_TEMP_THR;
      humid_thr_r <= smpc_pkg::RST_HUMID_THR;
      sat_level_r <= smpc_pkg::RST_SAT_LEVEL;
      dry_level_r <= smpc_pkg::RST_DRY_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smpc_pkg::REG_WET_RAW:   wet_raw_r   <= cfg_data[smpc_pkg::RAW_W-1:0];
        smpc_pkg::REG_DRY_RAW:   dry_raw_r   <= cfg_data[smpc_pkg::RAW_W-1:0];
        smpc_pkg::REG_READ_MIN:  read_min_r  <= cfg_data[smpc_pkg::RAW_W-1:0];
        smpc_pkg::REG_READ_MAX:  read_max_r  <= cfg_data[smpc_pkg::RAW_W-1:0];
        smpc_pkg::REG_TEMP_THR:  temp_thr_r  <= $signed(cfg_data[smpc_pkg::TEMP_W-1:0]);
        smpc_pkg::REG_HUMID_THR: humid_thr_r <= cfg_data[smpc_pkg::PCT_W-1:0];
        smpc_pkg::REG_SAT_LEVEL: sat_level_r <= cfg_data[smpc_pkg::PCT_W-1:0];
        smpc_pkg::REG_DRY_LEVEL: dry_level_r <= cfg_data[smpc_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item sequencer and block state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= '0;
      valid_sum_r    <= '0;
      valid_count_r  <= '0;
      moisture_r     <= '0;
      last_valid_r   <= smpc_pkg::RST_LAST_VALID;
      mode_manual_r  <= 1'b0;
      pump_r         <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (cmd_r) begin
            mode_manual_r <= 1'b1;
            pump_r        <= man_on_r;
            state_r       <= S_EMIT;
          end else if (!reading_end) begin
            sample_count_r <= scnt_nxt;
            valid_sum_r    <= sum_nxt;
            valid_count_r  <= vcnt_nxt;
            state_r        <= S_EMIT;
          end else begin
            sample_count_r <= '0;
            valid_sum_r    <= '0;
            valid_count_r  <= '0;
            if (vcnt_nxt != '0) begin
              state_r <= S_AVG;
            end else begin
              moisture_r <= last_valid_r;
              state_r    <= S_CTRL;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_MDIV;
        end
        S_MDIV: begin
          if (span == '0) begin
            // Equal calibration points: full at or below wet_raw, else dry.
            moisture_r   <= (x_r <= 0) ? smpc_pkg::PCT_FULL : '0;
            last_valid_r <= (x_r <= 0) ? smpc_pkg::PCT_FULL : '0;
            state_r      <= S_CTRL;
          end else begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          if (div_done) begin
            moisture_r   <= m_clamped;
            last_valid_r <= m_clamped;
            state_r      <= S_CTRL;
          end
        end
        S_CTRL: begin
          if (moisture_r > sat_level_r) begin
            pump_r        <= 1'b0;
            mode_manual_r <= 1'b0;
          end else if (!mode_manual_r) begin
            pump_r <= auto_run;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item capture and per-item working values.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r      <= in_command;
      raw_r      <= in_raw_sample;
      temp_r     <= in_temperature;
      humid_r    <= in_humidity;
      man_on_r   <= in_manual_on;
      done_r     <= 1'b0;
      fallback_r <= 1'b0;
    end else if (state_r == S_UPD && !cmd_r && reading_end) begin
      done_r     <= 1'b1;
      fallback_r <= (vcnt_nxt == '0);
    end
    if (state_r == S_AVG && div_done) begin
      x_r <= x_nxt;
    end
    if (state_r == S_MUL) begin
      n_r <= 18'sd0 - prod;
    end
    if (state_r == S_MDIV) begin
      neg_r <= n_r[17] ^ span[smpc_pkg::RAW_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pump_r <= pump_r;
      out_mode_r <= mode_manual_r;
      out_pct_r  <= moisture_r;
      out_done_r <= done_r;
      out_fb_r   <= fallback_r;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_pump_on       = out_pump_r;
  assign out_manual_mode   = out_mode_r;
  assign out_moisture_pct  = out_pct_r;
  assign out_reading_done  = out_done_r;
  assign out_used_fallback = out_fb_r;

endmodule

>>> hw/rtl/smpc_div.sv
module smpc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smpc_pkg::smpc_div_req_t             req,
  output logic                                done,
  output logic [smpc_pkg::DIV_NUM_W-1:0]      quotient
);

  logic                                busy_r;
  logic                                done_r;
  logic [smpc_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [smpc_pkg::DIV_DEN_W-1:0]      rem_r;
  logic [smpc_pkg::DIV_DEN_W-1:0]      den_r;
  logic [smpc_pkg::DIV_NUM_W-1:0]      quo_r;

  logic [smpc_pkg::DIV_DEN_W:0]        shifted;
  logic                                fits;
  logic [smpc_pkg::DIV_DEN_W:0]        diff;
  logic [smpc_pkg::DIV_DEN_W-1:0]      rem_nxt;

  // One restoring step: bring down the next numerator bit and try the divisor.
  always_comb begin
    shifted = {rem_r, quo_r[smpc_pkg::DIV_NUM_W-1]};
    fits    = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = fits ? diff[smpc_pkg::DIV_DEN_W-1:0] : shifted[smpc_pkg::DIV_DEN_W-1:0];
  end

  // Control of the iteration, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= smpc_pkg::DIV_CNT_W'(smpc_pkg::DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == smpc_pkg::DIV_CNT_W'(1));
      busy_r <= (cnt_r != smpc_pkg::DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[smpc_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
